@@ src/bsa_pkg.sv @@
// Shared constants, payload types, state codes and helpers of the bitmap slot allocator.
package bsa_pkg;

    localparam int NUM_SLOTS      = 1024;
    localparam int NUM_POOLS      = 4;
    localparam int SLOT_BYTES     = 64;

    localparam int WORD_W         = 64;
    localparam int BIT_W          = $clog2(WORD_W);
    localparam int WORDS_PER_POOL = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int NUM_WORDS      = NUM_POOLS * WORDS_PER_POOL;
    localparam int ADDR_W         = $clog2(NUM_WORDS);
    localparam int IDX_W          = $clog2(NUM_SLOTS);
    localparam int WSEL_W         = IDX_W - BIT_W;
    localparam int POOL_SEL_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;

    localparam int TOTAL_W        = 11;
    localparam int COUNT_W        = 11;
    localparam int META_W         = 21;
    localparam int POOLS_EN_W     = 4;
    localparam int OFF_W          = 32;
    localparam int POOL_W         = 2;
    localparam int STATUS_W       = 3;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = META_W;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET    = TOTAL_W'(1024);
    localparam logic [OFF_W-1:0]   INVALID_OFFSET = {OFF_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SLOTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_META_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOLS_ENABLED = 2'd2;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_READY    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL         = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_OFFSET   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_HELD         = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_WRITERS      = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 3'd6;

    typedef struct packed {
        logic              command;
        logic [POOL_W-1:0] pool;
        logic [OFF_W-1:0]  slot_offset;
        logic              lock_held;
        logic              writers_waiting;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    granted_offset;
        logic [COUNT_W-1:0]  allocated_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FREE_RD,
        S_FREE_EV,
        S_WRITE,
        S_PUSH
    } t_state;

    // Lowest set bit of a word: {found, position}.
    function automatic logic [BIT_W:0] first_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_W'(i);
            end
        end
        return {|v, pos};
    endfunction

endpackage

@@ src/bsa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/bitmap_slot_allocator.sv @@
// Top level of the next-fit bitmap slot allocator: sequencer, word scanner and pool state.
//
//   channel | direction | handshake                  | beat
//   --------+-----------+----------------------------+--------------------------------
//   in      | input     | i_in_valid / o_in_stall    | t_in_item  (command, pool, ...)
//   out     | output    | o_out_valid / i_out_stall  | t_out_item (status, offset, count)
//   cfg     | input     | i_cfg_we, i_cfg_idx        | i_cfg_wdata, no read-back
//
// An allocate visits at most ceil(total_slots/64) + 1 bitmap words, scanning one 64-bit word
// per cycle through the bitmap RAM read port.
// Reset clears the bitmap at once through per-word valid flags; no clearing pass.
// One result waits in the output register under stall while the next beat is taken in.
module bitmap_slot_allocator import bsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    t_state r_state, n_state;

    logic [TOTAL_W-1:0]    r_total;
    logic [META_W-1:0]     r_meta;
    logic [POOLS_EN_W-1:0] r_pools_en;
    logic [IDX_W-1:0]      r_hint  [NUM_POOLS];
    logic [COUNT_W-1:0]    r_count [NUM_POOLS];
    logic [NUM_WORDS-1:0]  r_wvld;

    t_in_item              r_item;
    logic [IDX_W-1:0]      r_start;
    logic [WSEL_W-1:0]     r_iss_w;
    logic                  r_iss_ph;
    logic                  r_iss_done;
    logic                  r_ev_valid;
    logic [WSEL_W-1:0]     r_ev_w;
    logic                  r_ev_ph;
    logic                  r_ev_last;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_idx;
    logic [WORD_W-1:0]     r_wdata;
    t_out_item             r_res;
    t_out_item             r_out;
    logic                  r_ovalid;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [POOL_SEL_W-1:0] w_pool;
    logic                  w_pool_ok;
    logic                  w_pool_en;
    logic [COUNT_W-1:0]    w_cnt;
    logic [TOTAL_W-1:0]    w_eff_total;
    logic [TOTAL_W-1:0]    w_tm1;
    logic [WSEL_W-1:0]     w_last_w;
    logic [BIT_W:0]        w_lim;
    logic [IDX_W-1:0]      w_start;
    logic [OFF_W-1:0]      w_hi;
    logic [OFF_W-1:0]      w_diff;
    logic                  w_bad_off;
    logic                  w_setup_done;
    logic [STATUS_W-1:0]   w_setup_status;
    logic [WSEL_W-1:0]     w_sw;
    logic [BIT_W-1:0]      w_sb;
    logic [WSEL_W-1:0]     w_rword;
    logic [ADDR_W-1:0]     w_raddr;
    logic [ADDR_W-1:0]     w_waddr;
    logic                  w_we;
    logic [WORD_W-1:0]     w_ram_q;
    logic [WORD_W-1:0]     w_word;
    logic [WORD_W-1:0]     w_lo_mask;
    logic [WORD_W-1:0]     w_hi_mask;
    logic [BIT_W:0]        w_enc;
    logic                  w_fnd;
    logic                  w_last_issue;
    logic                  w_free_bit;
    logic [IDX_W-1:0]      w_next_hint;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ovalid || !i_out_stall;

    // pool-level lookups
    assign w_pool    = r_item.pool[POOL_SEL_W-1:0];
    assign w_pool_ok = int'(r_item.pool) < NUM_POOLS;
    assign w_pool_en = r_pools_en[r_item.pool];
    assign w_cnt     = r_count[w_pool];

    // saturate total to the pool size
    assign w_eff_total = (r_total > TOTAL_W'(NUM_SLOTS)) ? TOTAL_W'(NUM_SLOTS) : r_total;
    assign w_tm1       = w_eff_total - TOTAL_W'(1);
    assign w_last_w    = w_tm1[IDX_W-1:BIT_W];
    assign w_lim       = {1'b0, w_tm1[BIT_W-1:0]} + (BIT_W+1)'(1);
    assign w_start     = (TOTAL_W'(r_hint[w_pool]) >= w_eff_total) ? '0 : r_hint[w_pool];

    // free range check, exact and without wrap
    assign w_hi      = OFF_W'(r_meta) + OFF_W'(w_eff_total) * OFF_W'(SLOT_BYTES);
    assign w_diff    = r_item.slot_offset - OFF_W'(r_meta);
    assign w_bad_off = (r_item.slot_offset == INVALID_OFFSET)
                    || (r_item.slot_offset < OFF_W'(r_meta))
                    || (r_item.slot_offset >= w_hi);

    always_comb begin
        w_setup_done   = 1'b1;
        w_setup_status = STAT_OK;
        if (!w_pool_ok || !w_pool_en) begin
            w_setup_status = STAT_NOT_READY;
        end else if (r_item.command == CMD_ALLOC) begin
            if (w_eff_total == '0) begin
                w_setup_status = STAT_FULL;
            end else begin
                w_setup_done = 1'b0;
            end
        end else if (w_bad_off) begin
            w_setup_status = STAT_BAD_OFFSET;
        end else if (r_item.lock_held) begin
            w_setup_status = STAT_HELD;
        end else if (r_item.writers_waiting) begin
            w_setup_status = STAT_WRITERS;
        end else begin
            w_setup_done = 1'b0;
        end
    end

    // bitmap RAM addressing
    assign w_sw    = r_start[IDX_W-1:BIT_W];
    assign w_sb    = r_start[BIT_W-1:0];
    assign w_rword = (r_state == S_SCAN) ? r_iss_w : r_idx[IDX_W-1:BIT_W];
    assign w_raddr = ADDR_W'(ADDR_W'(w_pool) * ADDR_W'(WORDS_PER_POOL) + ADDR_W'(w_rword));
    assign w_waddr = ADDR_W'(ADDR_W'(w_pool) * ADDR_W'(WORDS_PER_POOL)
                   + ADDR_W'(r_idx[IDX_W-1:BIT_W]));
    assign w_we    = (r_state == S_WRITE);

    bsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // a word never written since reset reads as all clear
    assign w_word = r_rd_vld ? w_ram_q : '0;

    // scan window of the word under evaluation: from the hint up to total, then wrap below it
    assign w_lo_mask = (r_ev_w != w_sw) ? ONES
                     : (r_ev_ph ? ~(ONES << w_sb) : (ONES << w_sb));
    assign w_hi_mask = (r_ev_w == w_last_w) ? ~(ONES << w_lim) : ONES;
    assign w_enc     = first_set(~w_word & w_lo_mask & w_hi_mask);
    assign w_fnd     = w_enc[BIT_W];

    assign w_last_issue = r_iss_ph && (r_iss_w == w_sw);
    assign w_free_bit   = w_word[r_idx[BIT_W-1:0]];
    assign w_next_hint  = (TOTAL_W'(r_idx) + TOTAL_W'(1) >= w_eff_total) ? '0
                        : r_idx + IDX_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (w_setup_done) begin
                    n_state = S_PUSH;
                end else if (r_item.command == CMD_ALLOC) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FREE_RD;
                end
            end
            S_SCAN: begin
                if (r_ev_valid && w_fnd) begin
                    n_state = S_WRITE;
                end else if (r_ev_valid && r_ev_last) begin
                    n_state = S_PUSH;
                end
            end
            S_FREE_RD: n_state = S_FREE_EV;
            S_FREE_EV: n_state = w_free_bit ? S_WRITE : S_PUSH;
            S_WRITE:   n_state = S_PUSH;
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // control and pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= TOTAL_RESET;
            r_meta     <= '0;
            r_pools_en <= '0;
            r_wvld     <= '0;
            r_ovalid   <= 1'b0;
            r_ev_valid <= 1'b0;
            for (int p = 0; p < NUM_POOLS; p++) begin
                r_hint[p]  <= '0;
                r_count[p] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOTAL_SLOTS:   r_total    <= i_cfg_wdata[TOTAL_W-1:0];
                    CFG_META_SIZE:     r_meta     <= i_cfg_wdata[META_W-1:0];
                    CFG_POOLS_ENABLED: r_pools_en <= i_cfg_wdata[POOLS_EN_W-1:0];
                    default: ;
                endcase
            end

            // issue one word read per scan cycle, evaluated in the next cycle
            if (r_state == S_SCAN) begin
                r_ev_valid <= !r_iss_done;
            end else begin
                r_ev_valid <= 1'b0;
            end

            if (r_state == S_WRITE) begin
                r_wvld[w_waddr] <= 1'b1;
                if (r_item.command == CMD_ALLOC) begin
                    r_count[w_pool] <= w_cnt + COUNT_W'(1);
                    r_hint[w_pool]  <= w_next_hint;
                end else if (w_cnt != '0) begin
                    r_count[w_pool] <= w_cnt - COUNT_W'(1);
                end
            end

            if (r_state == S_PUSH && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload and sequencing data
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_wvld[w_raddr];

        if (w_in_acc) begin
            r_item <= i_in_data;
        end

        case (r_state)
            S_SETUP: begin
                r_start    <= w_start;
                r_iss_w    <= w_start[IDX_W-1:BIT_W];
                r_iss_ph   <= 1'b0;
                r_iss_done <= 1'b0;
                r_idx      <= IDX_W'(w_diff / SLOT_BYTES);
                r_res.status          <= w_setup_status;
                r_res.granted_offset  <= '0;
                r_res.allocated_count <= w_pool_ok ? w_cnt : '0;
            end
            S_SCAN: begin
                if (!r_iss_done) begin
                    r_ev_w    <= r_iss_w;
                    r_ev_ph   <= r_iss_ph;
                    r_ev_last <= w_last_issue;
                    if (w_last_issue) begin
                        r_iss_done <= 1'b1;
                    end else if (!r_iss_ph && r_iss_w == w_last_w) begin
                        r_iss_ph <= 1'b1;
                        r_iss_w  <= '0;
                    end else begin
                        r_iss_w <= r_iss_w + WSEL_W'(1);
                    end
                end
                if (r_ev_valid && w_fnd) begin
                    r_idx   <= {r_ev_w, w_enc[BIT_W-1:0]};
                    r_wdata <= w_word | (WORD_W'(1) << w_enc[BIT_W-1:0]);
                end
                r_res.status          <= STAT_FULL;
                r_res.granted_offset  <= '0;
                r_res.allocated_count <= w_cnt;
            end
            S_FREE_EV: begin
                r_wdata <= w_word & ~(WORD_W'(1) << r_idx[BIT_W-1:0]);
                r_res.status          <= STAT_ALREADY_FREE;
                r_res.granted_offset  <= '0;
                r_res.allocated_count <= w_cnt;
            end
            S_WRITE: begin
                r_res.status <= STAT_OK;
                if (r_item.command == CMD_ALLOC) begin
                    r_res.granted_offset  <= OFF_W'(r_meta) + OFF_W'(r_idx) * OFF_W'(SLOT_BYTES);
                    r_res.allocated_count <= w_cnt + COUNT_W'(1);
                end else begin
                    r_res.granted_offset  <= '0;
                    r_res.allocated_count <= (w_cnt != '0) ? w_cnt - COUNT_W'(1) : '0;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

@@ src/bsa_checker.sv @@
// Port-level assertions for the bitmap slot allocator, bound to the top level.
module bsa_checker import bsa_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_item              i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed or dropped");

    // one item at a time: busy straight after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again while an item is in flight");

    a_offset_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != STAT_OK |-> o_out_data.granted_offset == '0)
        else $error("offset reported on a failed command");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.allocated_count <= COUNT_W'(NUM_SLOTS))
        else $error("allocated count beyond pool size");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

@@ bench/bitmap_slot_allocator_tb.sv @@
// Self-checking testbench of the bitmap slot allocator: directed and random command traffic.
`timescale 1ns / 1ps

module bitmap_slot_allocator_tb;
    import bsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int IDLE_PCT       = 37;
    localparam int META_MAX       = (1 << META_W) - 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // allocator state as the block ought to hold it
    logic [NUM_SLOTS-1:0] slot_map [NUM_POOLS];
    int unsigned          hint_of  [NUM_POOLS];
    int unsigned          used_of  [NUM_POOLS];
    int unsigned          total_reg;
    int unsigned          meta_reg;
    int unsigned          enabled_reg;

    t_out_item   outcomes_due [$];
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned idle_pct     = IDLE_PCT;

    bitmap_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned live_span();
        return (total_reg > NUM_SLOTS) ? NUM_SLOTS : total_reg;
    endfunction

    // Apply one command to the allocator state and return the result it gives.
    function automatic t_out_item allocator_outcome(input t_in_item item);
        t_out_item       res;
        int unsigned     p;
        int unsigned     span;
        int unsigned     idx;
        int unsigned     n;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned off;
        res  = '0;
        p    = item.pool;
        span = live_span();
        if (p >= NUM_POOLS) begin
            res.status = STAT_NOT_READY;
            return res;
        end
        res.allocated_count = COUNT_W'(used_of[p]);
        if (((enabled_reg >> p) & 1) == 0) begin
            res.status = STAT_NOT_READY;
            return res;
        end
        if (item.command == CMD_ALLOC) begin
            res.status = STAT_FULL;
            if (span == 0) begin
                return res;
            end
            // a hint left over from a larger total restarts the scan at slot zero
            idx = (hint_of[p] >= span) ? 0 : hint_of[p];
            for (n = 0; n < span; n++) begin
                if (!slot_map[p][idx]) begin
                    slot_map[p][idx]    = 1'b1;
                    used_of[p]++;
                    hint_of[p]          = (idx + 1 >= span) ? 0 : idx + 1;
                    res.status          = STAT_OK;
                    res.granted_offset  = OFF_W'(longint'(meta_reg) + longint'(idx) * SLOT_BYTES);
                    res.allocated_count = COUNT_W'(used_of[p]);
                    return res;
                end
                idx = (idx + 1 >= span) ? 0 : idx + 1;
            end
            return res;
        end
        lo  = meta_reg;
        hi  = lo + longint'(span) * SLOT_BYTES;
        off = item.slot_offset;
        if (item.slot_offset == INVALID_OFFSET || off < lo || off >= hi) begin
            res.status = STAT_BAD_OFFSET;
        end else if (item.lock_held) begin
            res.status = STAT_HELD;
        end else if (item.writers_waiting) begin
            res.status = STAT_WRITERS;
        end else begin
            idx = int'((off - lo) / SLOT_BYTES);
            if (!slot_map[p][idx]) begin
                res.status = STAT_ALREADY_FREE;
            end else begin
                slot_map[p][idx] = 1'b0;
                if (used_of[p] > 0) begin
                    used_of[p]--;
                end
                res.status          = STAT_OK;
                res.allocated_count = COUNT_W'(used_of[p]);
            end
        end
        return res;
    endfunction

    function automatic t_in_item command_beat(input logic cmd, input int unsigned pool,
                                              input longint unsigned offset,
                                              input logic held, input logic waiting);
        t_in_item item;
        item.command         = cmd;
        item.pool            = POOL_W'(pool);
        item.slot_offset     = OFF_W'(offset);
        item.lock_held       = held;
        item.writers_waiting = waiting;
        return item;
    endfunction

    // Find an allocated slot below the current total, starting at a random place.
    function automatic int live_slot(input int unsigned p, input int unsigned span);
        int unsigned idx;
        int unsigned n;
        if (span == 0) begin
            return -1;
        end
        idx = $urandom_range(span - 1);
        for (n = 0; n < span; n++) begin
            if (slot_map[p][idx]) begin
                return int'(idx);
            end
            idx = (idx + 1 == span) ? 0 : idx + 1;
        end
        return -1;
    endfunction

    function automatic t_in_item random_command();
        t_in_item        item;
        int unsigned     span;
        int unsigned     pick;
        int              live;
        longint unsigned base;
        span                 = live_span();
        base                 = meta_reg;
        item.pool            = POOL_W'($urandom_range(NUM_POOLS - 1));
        item.lock_held       = ($urandom_range(9) == 0);
        item.writers_waiting = ($urandom_range(9) == 0);
        item.slot_offset     = $urandom;
        item.command         = CMD_FREE;
        pick                 = $urandom_range(99);
        if (pick < 45) begin
            item.command = CMD_ALLOC;
        end else if (pick < 80) begin
            live = live_slot(item.pool, span);
            if (live >= 0) begin
                item.slot_offset = OFF_W'(base + longint'(live) * SLOT_BYTES
                                          + $urandom_range(SLOT_BYTES - 1));
            end
        end else if (pick < 92) begin
            if (span > 0) begin
                item.slot_offset = OFF_W'(base + $urandom_range(span * SLOT_BYTES - 1));
            end
        end else begin
            case ($urandom_range(3))
                0: item.slot_offset = INVALID_OFFSET;
                1: item.slot_offset = OFF_W'(base - 1);
                2: item.slot_offset = OFF_W'(base + longint'(span) * SLOT_BYTES);
                default: item.slot_offset = $urandom;
            endcase
        end
        return item;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Called just after a falling edge; returns just after the falling edge past acceptance.
    task automatic issue_command(input t_in_item item);
        while ($urandom_range(99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        outcomes_due.push_back(allocator_outcome(item));
        @(negedge i_clk);
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic settle();
        in_valid = 1'b0;
        while (outcomes_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = CFG_DATA_W'(value);
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_TOTAL_SLOTS:   total_reg   = value & ((1 << TOTAL_W) - 1);
            CFG_META_SIZE:     meta_reg    = value & META_MAX;
            CFG_POOLS_ENABLED: enabled_reg = value & ((1 << POOLS_EN_W) - 1);
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned total, input int unsigned meta,
                              input int unsigned pools);
        settle();
        write_reg(CFG_TOTAL_SLOTS, total);
        write_reg(CFG_META_SIZE, meta);
        write_reg(CFG_POOLS_ENABLED, pools);
    endtask

    task automatic test_unready_pools();
        issue_command(command_beat(CMD_ALLOC, 0, 0, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 3, 0, 1'b1, 1'b1));
    endtask

    task automatic test_alloc_until_full();
        set_config(3, META_MAX, 4'hF);
        repeat (4) issue_command(command_beat(CMD_ALLOC, 1, $urandom, 1'b1, 1'b0));
        issue_command(command_beat(CMD_ALLOC, 2, 0, 1'b0, 1'b1));
    endtask

    // Each free check in priority order on pool 1, slots at META_MAX + k*SLOT_BYTES.
    task automatic test_free_checks();
        longint unsigned base;
        base = META_MAX;
        issue_command(command_beat(CMD_FREE, 1, INVALID_OFFSET, 1'b1, 1'b0));
        issue_command(command_beat(CMD_FREE, 1, base - 1, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 1, base + 3 * SLOT_BYTES, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 1, base + 3 * SLOT_BYTES - 1, 1'b1, 1'b1));
        issue_command(command_beat(CMD_FREE, 1, base + 3 * SLOT_BYTES - 1, 1'b0, 1'b1));
        issue_command(command_beat(CMD_FREE, 1, base + 3 * SLOT_BYTES - 1, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 1, base + 3 * SLOT_BYTES - 1, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 1, base + SLOT_BYTES + 1, 1'b0, 1'b0));
        issue_command(command_beat(CMD_ALLOC, 1, 0, 1'b0, 1'b0));
    endtask

    task automatic test_zero_total();
        set_config(0, META_MAX, 4'hF);
        issue_command(command_beat(CMD_ALLOC, 1, 0, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 1, META_MAX, 1'b0, 1'b0));
    endtask

    // Pool 2 holds a hint of one, which a total of one makes stale.
    task automatic test_stale_hint_and_saturation();
        set_config(1, 0, 4'hF);
        issue_command(command_beat(CMD_ALLOC, 2, 0, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 2, 0, 1'b0, 1'b0));
        issue_command(command_beat(CMD_ALLOC, 2, 0, 1'b0, 1'b0));
        set_config((1 << TOTAL_W) - 1, 0, 4'hF);
        issue_command(command_beat(CMD_ALLOC, 3, 0, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 3, NUM_SLOTS * SLOT_BYTES - 1, 1'b0, 1'b0));
        issue_command(command_beat(CMD_FREE, 3, NUM_SLOTS * SLOT_BYTES, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic(input int phases, input int items);
        int unsigned total;
        int unsigned meta;
        int unsigned pools;
        repeat (phases) begin
            case ($urandom_range(9))
                0: total = 0;
                1: total = 1;
                2: total = (1 << TOTAL_W) - 1;
                3: total = NUM_SLOTS;
                4: total = $urandom_range((1 << TOTAL_W) - 1);
                default: total = $urandom_range(96, 2);
            endcase
            case ($urandom_range(3))
                0: meta = 0;
                1: meta = META_MAX;
                default: meta = $urandom_range(META_MAX);
            endcase
            pools = ($urandom_range(2) == 0) ? $urandom_range(15) : 15;
            set_config(total, meta, pools);
            repeat (items) issue_command(random_command());
        end
    endtask

    task automatic test_calm_stretch();
        idle_pct = 0;
        test_random_traffic(1, 120);
        idle_pct = IDLE_PCT;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_TOTAL_SLOTS;
        cfg_wdata = '0;
        for (int p = 0; p < NUM_POOLS; p++) begin
            slot_map[p] = '0;
            hint_of[p]  = 0;
            used_of[p]  = 0;
        end
        total_reg   = TOTAL_RESET;
        meta_reg    = 0;
        enabled_reg = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unready_pools();
        test_alloc_until_full();
        test_free_checks();
        test_zero_total();
        test_stale_hint_and_saturation();
        test_random_traffic(3, 112);
        test_calm_stretch();
        test_random_traffic(4, 112);

        settle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    // Compare each result beat with the oldest outstanding one, field by field.
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && out_valid && !out_stall) begin
            if (outcomes_due.size() == 0) begin
                flag_mismatch($sformatf("result beat with none outstanding: status %0d",
                                        out_data.status));
            end else begin
                due = outcomes_due.pop_front();
                if (out_data.status !== due.status) begin
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            out_data.status, due.status));
                end
                if (out_data.granted_offset !== due.granted_offset) begin
                    flag_mismatch($sformatf("granted_offset %h, want %h",
                                            out_data.granted_offset, due.granted_offset));
                end
                if (out_data.allocated_count !== due.allocated_count) begin
                    flag_mismatch($sformatf("allocated_count %0d, want %0d",
                                            out_data.allocated_count, due.allocated_count));
                end
            end
        end
    end

    // Stop a hung run: count cycles in which no beat moves on any port.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
